### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/plac_pkg.sv
package plac_pkg;

	localparam int unsigned CoordW = 32;
	localparam int unsigned DiffW = 33;
	localparam int unsigned LenW = 34;
	localparam int unsigned SqW = 68;
	localparam int unsigned TotalW = 40;
	localparam int unsigned HeadW = 19;
	localparam int unsigned CurvW = 32;
	localparam int unsigned NumW = 50;
	localparam int unsigned CordW = 36;
	localparam int unsigned ZW = 20;
	localparam int unsigned Iters = 16;

	localparam logic signed [ZW-1:0] PiQ = 20'sd205887;
	localparam logic signed [ZW-1:0] HalfPiQ = 20'sd102944;
	localparam logic signed [ZW-1:0] TwoPiQ = 20'sd411775;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SQRT,
		ST_CORDIC,
		ST_DTH,
		ST_DIV1,
		ST_KAP,
		ST_DIV2,
		ST_DONE
	} plac_state_t;

	// request to the shared divider
	typedef struct packed {
		logic start;
		logic [NumW-1:0] num;
		logic [LenW-1:0] den;
	} plac_div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [NumW-1:0] quo;
	} plac_div_rsp_t;

	function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] i);
		logic signed [ZW-1:0] v;
		case (i)
			4'd0: v = 20'sd51472;
			4'd1: v = 20'sd30386;
			4'd2: v = 20'sd16055;
			4'd3: v = 20'sd8150;
			4'd4: v = 20'sd4091;
			4'd5: v = 20'sd2047;
			4'd6: v = 20'sd1024;
			4'd7: v = 20'sd512;
			4'd8: v = 20'sd256;
			4'd9: v = 20'sd128;
			4'd10: v = 20'sd64;
			4'd11: v = 20'sd32;
			4'd12: v = 20'sd16;
			4'd13: v = 20'sd8;
			4'd14: v = 20'sd4;
			default: v = 20'sd2;
		endcase
		return v;
	endfunction

endpackage

### rtl/plac_div.sv
// restoring divider, one quotient bit per cycle, unsigned
module plac_div
	import plac_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  plac_div_req_t req,
	output plac_div_rsp_t rsp
);

	logic [NumW-1:0] quo_q;
	logic [LenW:0] rem_q;
	logic [LenW-1:0] den_q;
	logic [$clog2(NumW+1)-1:0] cnt_q;
	logic busy_q, done_q;
	logic [LenW+1:0] trial;

	assign trial = {rem_q, quo_q[NumW-1]} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= ($clog2(NumW+1))'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift and subtract step
	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[LenW+1]) begin
				rem_q <= trial[LenW:0];
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[LenW-1:0], quo_q[NumW-1]};
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo = quo_q;

endmodule

### rtl/polyline_arc_length_curvature_unit.sv
// Polyline arc length, heading and curvature over a stream of waypoints, one waypoint per
// item. The block takes a new item only when it is idle and its result register is empty,
// so items are handled one at a time. The first point of a path goes from the load step
// straight to the output step. Otherwise the load step is followed by 34 bit-by-bit square
// root steps, 16 CORDIC vectoring steps (1 when the segment lies on an axis or has zero
// length), a heading wrap step and the output step; this ends a second point or a
// zero-length segment. From the third point of a path on, a nonzero segment also needs
// two 50-step divisions on one shared restoring divider, with a setup step between them;
// the divider sets most of the latency. The result is held in an output register, and the
// next item is accepted once it has been taken.
`include "assert_macros.svh"
module polyline_arc_length_curvature_unit
	import plac_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [63:0]  s_axis_tdata,  // x_coord[31:0], y_coord[63:32]
	input  logic         s_axis_tuser,  // path_start
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // arc_length, heading, curvature, curvature_rate
	output logic         m_axis_tuser   // zero_segment
);

	plac_state_t state_q, state_d;

	logic signed [CoordW-1:0] last_x_q, last_y_q, in_x_q, in_y_q;
	logic signed [HeadW-1:0] last_head_q, head_q;
	logic signed [CurvW-1:0] last_kap_q, kap_q, rate_q;
	logic [TotalW-1:0] total_q;
	logic [1:0] seen_q;
	logic start_q;

	logic signed [DiffW-1:0] dx_q, dy_q;
	logic [SqW-1:0] sum_sq_q;
	logic [LenW-1:0] root_q;
	logic [5:0] bit_q;
	logic signed [CordW-1:0] cx_q, cy_q;
	logic signed [ZW-1:0] cz_q;
	logic [3:0] it_q;
	logic spec_q;
	logic signed [ZW-1:0] spec_z_q;
	logic neg_q;

	logic out_valid_q;
	logic [TotalW-1:0] o_len_q;
	logic signed [HeadW-1:0] o_head_q;
	logic signed [CurvW-1:0] o_kap_q, o_rate_q;
	logic o_zero_q;

	plac_div_req_t div_req;
	plac_div_rsp_t div_rsp;

	plac_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	logic accept;
	assign s_axis_tready = (state_q == ST_IDLE) && !out_valid_q;
	assign accept = s_axis_tvalid && s_axis_tready;

	// squares of the difference magnitudes
	logic [CoordW-1:0] ax, ay;
	logic [2*CoordW-1:0] ax_sq, ay_sq;
	assign ax = dx_q[DiffW-1] ? CoordW'(-dx_q) : CoordW'(dx_q);
	assign ay = dy_q[DiffW-1] ? CoordW'(-dy_q) : CoordW'(dy_q);
	assign ax_sq = ax * ax;
	assign ay_sq = ay * ay;

	// sqrt trial: (root | 1<<bit)^2 <= sum
	logic [LenW-1:0] cand;
	logic [SqW-1:0] cand_sq;
	assign cand = root_q | (LenW'(1) << bit_q);
	assign cand_sq = cand * cand;

	// cordic step
	logic signed [CordW-1:0] xs, ys;
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;

	// final heading, clamped
	logic signed [HeadW-1:0] head_new;
	always_comb begin
		if (spec_q) head_new = HeadW'(spec_z_q);
		else if (cz_q > PiQ) head_new = HeadW'(PiQ);
		else if (cz_q < -PiQ) head_new = HeadW'(-PiQ);
		else head_new = HeadW'(cz_q);
	end

	// heading difference, wrapped
	logic signed [ZW:0] dth_raw, dth;
	always_comb begin
		dth_raw = (ZW+1)'(head_new) - (ZW+1)'(last_head_q);
		if (dth_raw > (ZW+1)'(PiQ)) dth = dth_raw - (ZW+1)'(TwoPiQ);
		else if (dth_raw < -(ZW+1)'(PiQ)) dth = dth_raw + (ZW+1)'(TwoPiQ);
		else dth = dth_raw;
	end

	// saturated signed result of the divider
	logic signed [CurvW-1:0] div_sat;
	always_comb begin
		if (neg_q) div_sat = (div_rsp.quo > NumW'(64'd2147483648)) ? 32'sh80000000
			: -CurvW'(div_rsp.quo);
		else div_sat = (div_rsp.quo > NumW'(64'd2147483647)) ? 32'sh7fffffff
			: CurvW'(div_rsp.quo);
	end

	logic signed [CurvW:0] kdiff;
	assign kdiff = (CurvW+1)'(kap_q) - (CurvW+1)'(last_kap_q);

	logic [TotalW:0] tot_sum;
	assign tot_sum = {1'b0, total_q} + (TotalW+1)'(root_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		div_req.start = 1'b0;
		div_req.num = '0;
		div_req.den = root_q;
		case (state_q)
			ST_IDLE: if (accept) state_d = ST_LOAD;
			ST_LOAD: if (start_q || seen_q == 2'd0) state_d = ST_DONE;
				else state_d = ST_SQRT;
			ST_SQRT: if (bit_q == 6'd0) state_d = ST_CORDIC;
			ST_CORDIC: if (spec_q || it_q == 4'd15) state_d = ST_DTH;
			ST_DTH: if (seen_q == 2'd2 && root_q != '0) begin
					div_req.start = 1'b1;
					div_req.num = NumW'(dth < 0 ? -dth : dth) << 16;
					state_d = ST_DIV1;
				end else state_d = ST_DONE;
			ST_DIV1: if (div_rsp.done) state_d = ST_KAP;
			ST_KAP: begin
				div_req.start = 1'b1;
				div_req.num = NumW'(kdiff < 0 ? -kdiff : kdiff) << 16;
				state_d = ST_DIV2;
			end
			ST_DIV2: if (div_rsp.done) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
			last_head_q <= '0;
			last_kap_q <= '0;
			total_q <= '0;
			seen_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) out_valid_q <= 1'b0;
			if (state_q == ST_DONE) begin
				out_valid_q <= 1'b1;
				last_x_q <= in_x_q;
				last_y_q <= in_y_q;
				if (start_q || seen_q == 2'd0) begin
					last_head_q <= '0;
					last_kap_q <= '0;
					total_q <= '0;
					seen_q <= 2'd1;
				end else begin
					last_head_q <= head_q;
					last_kap_q <= kap_q;
					total_q <= tot_sum[TotalW] ? '1 : tot_sum[TotalW-1:0];
					seen_q <= 2'd2;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) begin
				in_x_q <= s_axis_tdata[31:0];
				in_y_q <= s_axis_tdata[63:32];
				start_q <= s_axis_tuser;
			end
			ST_LOAD: begin
				dx_q <= DiffW'(in_x_q) - DiffW'(last_x_q);
				dy_q <= DiffW'(in_y_q) - DiffW'(last_y_q);
				root_q <= '0;
				bit_q <= 6'd33;
				kap_q <= '0;
				rate_q <= '0;
				head_q <= '0;
			end
			ST_SQRT: begin
				if (bit_q == 6'd33) sum_sq_q <= SqW'(ax_sq) + SqW'(ay_sq);
				else if (cand_sq <= sum_sq_q) root_q <= cand;
				bit_q <= bit_q - 6'd1;
				it_q <= '0;
				spec_q <= (dx_q == '0) || (dy_q == '0);
				spec_z_q <= (dy_q == '0) ? ((dx_q < 0) ? PiQ : '0)
					: ((dy_q < 0) ? -HalfPiQ : HalfPiQ);
				if (dx_q < 0) begin
					cx_q <= -CordW'(dx_q);
					cy_q <= -CordW'(dy_q);
					cz_q <= (dy_q >= 0) ? PiQ : -PiQ;
				end else begin
					cx_q <= CordW'(dx_q);
					cy_q <= CordW'(dy_q);
					cz_q <= '0;
				end
			end
			ST_CORDIC: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + atan_lut(it_q);
				end else begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - atan_lut(it_q);
				end
				it_q <= it_q + 4'd1;
			end
			ST_DTH: begin
				head_q <= head_new;
				neg_q <= dth < 0;
			end
			ST_DIV1: if (div_rsp.done) kap_q <= div_sat;
			ST_KAP: neg_q <= kdiff < 0;
			ST_DIV2: if (div_rsp.done) rate_q <= div_sat;
			ST_DONE: begin
				o_zero_q <= !(start_q || seen_q == 2'd0) && root_q == '0;
				if (start_q || seen_q == 2'd0) begin
					o_len_q <= '0;
					o_head_q <= '0;
					o_kap_q <= '0;
					o_rate_q <= '0;
				end else begin
					o_len_q <= tot_sum[TotalW] ? '1 : tot_sum[TotalW-1:0];
					o_head_q <= head_q;
					o_kap_q <= kap_q;
					o_rate_q <= rate_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {5'd0, o_rate_q, o_kap_q, o_head_q, o_len_q};
	assign m_axis_tuser = o_zero_q;

	`ASSERT_CLK(a_no_accept_busy, clk, arst_n, accept |-> !out_valid_q, "accept while busy")
	`ASSERT_CLK(a_div_idle_start, clk, arst_n, div_req.start |-> !div_rsp.busy, "div restart")
	`ASSERT_CLK(a_done_valid, clk, arst_n, state_q == ST_DONE |=> out_valid_q, "no result")
	`ASSERT_NEVER(a_ready_with_result, clk, arst_n, s_axis_tready && m_axis_tvalid, "ready with result")

endmodule

### test/tb_polyline_arc_length_curvature_unit.sv
`timescale 1ns / 100ps

module tb_polyline_arc_length_curvature_unit;

	localparam longint PI_FX = 205887;
	localparam longint TWO_PI_FX = 411775;
	localparam longint CURV_MAX = 64'sd2147483647;
	localparam longint CURV_MIN = -64'sd2147483648;
	localparam logic [39:0] ARC_MAX = 40'hFF_FFFF_FFFF;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        start;
	} waypoint_t;

	typedef struct {
		logic [39:0]        arc;
		logic signed [18:0] hdg;
		logic [31:0]        kap;
		logic [31:0]        rate;
		logic               zero_seg;
	} geom_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [63:0]  s_axis_tdata;  // x_coord[31:0], y_coord[63:32]
	logic         s_axis_tuser;  // path_start
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;  // arc_length, heading, curvature, curvature_rate
	logic         m_axis_tuser;  // zero_segment

	polyline_arc_length_curvature_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	waypoint_t waypoint_q[$];
	geom_t     geom_q[$];

	// predictor state
	logic [31:0] prev_x, prev_y;
	longint      prev_hdg, prev_kap;
	logic [39:0] total_len;
	int          seen_cnt;

	int     err_cnt, item_cnt, result_cnt, zero_cnt, sat_cnt, path_cnt;
	int     send_idle_pct, recv_stall_pct, hold_cycles;
	logic   in_fire;
	longint ax_step;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("timeout with %0d results outstanding", geom_q.size());
		$display("== FAIL ==");
		$finish;
	end

	// floor square root of dx^2 + dy^2
	function automatic logic [33:0] isqrt(input longint dx, input longint dy);
		logic [67:0] ax, ay, sum, c2;
		logic [33:0] r, c;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		sum = ax * ax + ay * ay;
		r = '0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (34'd1 << b);
			c2 = {34'd0, c} * {34'd0, c};
			if (c2 <= sum) r = c;
		end
		return r;
	endfunction

	// cordic vectoring angle in q2.16
	function automatic longint angle_of(input longint dx, input longint dy);
		longint x, y, z, xs, ys, t;
		x = dx;
		y = dy;
		z = 0;
		if (dx == 0 && dy == 0) return 0;
		if (dy == 0) return (dx < 0) ? PI_FX : 0;
		if (dx == 0) return (dy < 0) ? -102944 : 102944;
		if (dx < 0) begin
			x = -dx;
			y = -dy;
			z = (dy >= 0) ? PI_FX : -PI_FX;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			case (i)
				0: t = 51472;
				1: t = 30386;
				2: t = 16055;
				3: t = 8150;
				4: t = 4091;
				5: t = 2047;
				6: t = 1024;
				7: t = 512;
				8: t = 256;
				9: t = 128;
				10: t = 64;
				11: t = 32;
				12: t = 16;
				13: t = 8;
				14: t = 4;
				default: t = 2;
			endcase
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + t;
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - t;
			end
		end
		if (z > PI_FX) z = PI_FX;
		if (z < -PI_FX) z = -PI_FX;
		return z;
	endfunction

	// truncating divide with 32-bit signed saturation
	function automatic longint sat_div(input longint num, input longint den);
		longint unsigned mag, q;
		mag = (num < 0) ? -num : num;
		q = mag / den;
		if (num < 0) return (q > 64'd2147483648) ? CURV_MIN : -longint'(q);
		return (q > 64'd2147483647) ? CURV_MAX : longint'(q);
	endfunction

	// next expected geometry for one waypoint
	function automatic geom_t track_waypoint(input waypoint_t w);
		geom_t       g;
		longint      dx, dy, hd, kap, rate, dth;
		logic [33:0] len;
		logic [40:0] sum;
		g = '{default: '0};
		if (w.start || seen_cnt == 0) begin
			prev_x = w.x;
			prev_y = w.y;
			prev_hdg = 0;
			prev_kap = 0;
			total_len = '0;
			seen_cnt = 1;
			path_cnt++;
			return g;
		end
		dx = longint'($signed(w.x)) - longint'($signed(prev_x));
		dy = longint'($signed(w.y)) - longint'($signed(prev_y));
		len = isqrt(dx, dy);
		hd = angle_of(dx, dy);
		kap = 0;
		rate = 0;
		sum = {1'b0, total_len} + {7'd0, len};
		total_len = sum[40] ? ARC_MAX : sum[39:0];
		if (seen_cnt >= 2 && len != 0) begin
			dth = hd - prev_hdg;
			if (dth > PI_FX) dth -= TWO_PI_FX;
			else if (dth < -PI_FX) dth += TWO_PI_FX;
			kap = sat_div(dth * 65536, longint'(len));
			rate = sat_div((kap - prev_kap) * 65536, longint'(len));
			if (kap == CURV_MAX || kap == CURV_MIN || rate == CURV_MAX || rate == CURV_MIN)
				sat_cnt++;
		end
		prev_x = w.x;
		prev_y = w.y;
		prev_hdg = hd;
		prev_kap = kap;
		seen_cnt = 2;
		g.arc = total_len;
		g.hdg = hd[18:0];
		g.kap = kap[31:0];
		g.rate = rate[31:0];
		g.zero_seg = (len == 0);
		return g;
	endfunction

	task automatic report_mismatch(input string field, input longint exp_v, input longint got_v);
		$display("mismatch on result %0d, %s: expected %0d got %0d", result_cnt, field, exp_v,
			got_v);
		err_cnt++;
	endtask

	// sample both sides at the rising edge
	always @(posedge clk or negedge arst_n) begin
		geom_t e, g;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				g = track_waypoint('{x: s_axis_tdata[31:0],
					y: s_axis_tdata[63:32], start: s_axis_tuser});
				geom_q.insert(geom_q.size(), g);
				item_cnt++;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (geom_q.size() == 0) begin
					$display("unexpected result %0d", result_cnt);
					err_cnt++;
				end else begin
					e = geom_q.pop_front();
					if (m_axis_tdata[39:0] !== e.arc)
						report_mismatch("arc_length", e.arc, m_axis_tdata[39:0]);
					if (m_axis_tdata[58:40] !== e.hdg)
						report_mismatch("heading", e.hdg, $signed(m_axis_tdata[58:40]));
					if (m_axis_tdata[90:59] !== e.kap)
						report_mismatch("curvature", $signed(e.kap),
							$signed(m_axis_tdata[90:59]));
					if (m_axis_tdata[122:91] !== e.rate)
						report_mismatch("curvature_rate", $signed(e.rate),
							$signed(m_axis_tdata[122:91]));
					if (m_axis_tuser !== e.zero_seg)
						report_mismatch("zero_segment", e.zero_seg, m_axis_tuser);
					if (e.zero_seg) zero_cnt++;
				end
				result_cnt++;
			end
		end
	end

	// input driver, fed from the waypoint queue
	always @(negedge clk) begin
		waypoint_t w;
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			if (waypoint_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				w = waypoint_q.pop_front();
				s_axis_tdata <= {w.y, w.x};
				s_axis_tuser <= w.start;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// output back-pressure, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic add_point(input logic [31:0] x, input logic [31:0] y, input logic start);
		waypoint_t w;
		w = '{x: x, y: y, start: start};
		waypoint_q.insert(waypoint_q.size(), w);
	endtask

	task automatic drain;
		while (waypoint_q.size() > 0 || s_axis_tvalid || geom_q.size() > 0) @(posedge clk);
	endtask

	// random path: mostly well formed walks, some noise
	task automatic add_random(input int n);
		logic [31:0] x, y;
		int          len, k;
		while (n > 0) begin
			if ($urandom_range(9) < 8) begin
				x = $urandom;
				y = $urandom;
				add_point(x, y, 1'b1);
				len = $urandom_range(2, 20);
				k = $urandom_range(0, 30);
				for (int i = 1; i < len; i++) begin
					ax_step = longint'(1) << k;
					x = x + 32'(longint'($urandom_range(0, 2 * ax_step)) - ax_step);
					y = y + 32'(longint'($urandom_range(0, 2 * ax_step)) - ax_step);
					if ($urandom_range(15) == 0) k = $urandom_range(0, 30);
					add_point(x, y, 1'b0);
				end
				n -= len;
			end else begin
				add_point($urandom, $urandom, ($urandom_range(3) == 0));
				n--;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		err_cnt = 0;
		item_cnt = 0;
		result_cnt = 0;
		zero_cnt = 0;
		sat_cnt = 0;
		path_cnt = 0;
		prev_x = '0;
		prev_y = '0;
		prev_hdg = 0;
		prev_kap = 0;
		total_len = '0;
		seen_cnt = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: first point without start flag, zero segments, axis headings
		add_point(32'h0, 32'h0, 1'b0);
		add_point(32'h0, 32'h0, 1'b0);
		add_point(32'h0001_0000, 32'h0, 1'b0);
		add_point(32'h0001_0000, 32'h0001_0000, 1'b0);
		add_point(32'h0, 32'h0001_0000, 1'b0);
		add_point(32'h0, 32'h0, 1'b0);
		add_point(32'h0, 32'h0, 1'b0);
		add_point(32'hFFFF_0000, 32'h0000_8000, 1'b0);
		add_point(32'hFFFF_0001, 32'h0000_8000, 1'b0);
		add_point(32'hFFFF_0001, 32'h0000_8001, 1'b0);
		add_point(32'hFFFF_0000, 32'h0000_8000, 1'b0);
		add_point(32'hFFFF_0001, 32'h0000_8001, 1'b0);
		// extremes of the coordinates
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		add_point(32'h8000_0000, 32'h8000_0000, 1'b0);
		add_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
		add_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
		add_point(32'h8000_0000, 32'h8000_0000, 1'b0);
		add_point(32'hFFFF_FFFF, 32'h0, 1'b1);
		add_point(32'h0, 32'hFFFF_FFFF, 1'b0);
		add_point(32'h1234_5678, 32'h0, 1'b1);
		drain();

		// long arc lengths, short of saturation: zig-zag between corners of the coordinate range
		add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		for (int i = 0; i < 100; i++)
			add_point(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000,
				i[0] ? 32'h7FFF_FFFF : ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF),
				1'b0);
		drain();

		// random phases with different idling
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 84 : 32) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 84 : 32) : 0;
			add_random(100);
			if (ph == 0) begin
				@(negedge clk);
				hold_cycles = 2000;
			end
			drain();
		end

		repeat (300) @(posedge clk);
		$display("covered %0d waypoints over %0d paths, %0d results", item_cnt, path_cnt,
			result_cnt);
		$display("%0d zero-length segments, %0d saturated curvature results", zero_cnt, sat_cnt);
		if (err_cnt == 0 && geom_q.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

### polyline_arc_length_curvature_unit.f
+incdir+rtl
rtl/plac_pkg.sv
rtl/plac_div.sv
rtl/polyline_arc_length_curvature_unit.sv
test/tb_polyline_arc_length_curvature_unit.sv
